// ===== hw/rtl/tcgr_pkg.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer package
// Shared item, result, command and configuration types, character codes and
// the small coordinate helpers used by the renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        fill_background;
    logic [3:0]  glyph_row;
    logic [7:0]  glyph_bits;
    logic [15:0] cursor_x;
    logic [15:0] cursor_y;
  } item_t;

  typedef struct packed {
    logic [15:0] row_x;
    logic [15:0] row_y;
    logic [7:0]  row_bits;
    logic [31:0] pixel_fg;
    logic [31:0] pixel_bg;
    logic        paint_background;
    logic        status;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [15:0] region_left;
    logic [15:0] region_top;
    logic [15:0] region_right;
    logic [15:0] region_bottom;
    logic [3:0]  glyph_width;
    logic [4:0]  glyph_height;
    logic        wrap_enable;
  } cfg_t;

  localparam logic [1:0] MODE_CHAR   = 2'd0;
  localparam logic [1:0] MODE_FONT   = 2'd1;
  localparam logic [1:0] MODE_CURSOR = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam int         TAB_SPACES   = 4;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_GLYPH,
    CMD_NEWLINE,
    CMD_RETURN,
    CMD_TAB,
    CMD_FONT,
    CMD_CURSOR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  code;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        fill;
    logic [3:0]  row;
    logic [7:0]  bits;
    logic [15:0] cx;
    logic [15:0] cy;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETCUR,
    ST_TRAP1_X,
    ST_TRAP1_Y,
    ST_CTRL,
    ST_EMIT,
    ST_ADV,
    ST_TAB_X,
    ST_TAB_Y,
    ST_TRAP2_X,
    ST_TRAP2_Y
  } back_state_t;

  function automatic logic [15:0] sat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [15:0] sub0(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? (a - b) : 16'd0;
  endfunction

  function automatic logic [7:0] width_mask(input logic [3:0] w);
    logic [15:0] t;
    t = 16'hFF00 >> w;
    return t[7:0];
  endfunction

endpackage

// ===== hw/rtl/tcgr_front.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer front end
// Accepts input items and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
module tcgr_front #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic            item_valid,
  output logic            item_ready,
  input  tcgr_pkg::item_t item,
  input  logic            q_full,
  output logic            push,
  output tcgr_pkg::cmd_t  cmd
);
  import tcgr_pkg::*;

  localparam logic [8:0] CODE_LIMIT = 9'(GLYPH_COUNT);
  localparam logic [5:0] ROW_LIMIT  = 6'(MAX_GLYPH_ROWS);

  cmd_kind_t kind;

  always_comb begin
    case (item.mode)
      MODE_CHAR: begin
        case (item.char_code)
          CHAR_NEWLINE: kind = CMD_NEWLINE;
          CHAR_RETURN:  kind = CMD_RETURN;
          CHAR_TAB:     kind = CMD_TAB;
          default:      kind = CMD_GLYPH;
        endcase
      end
      MODE_FONT: begin
        if (({1'b0, item.char_code} < CODE_LIMIT) && ({2'b00, item.glyph_row} < ROW_LIMIT)) begin
          kind = CMD_FONT;
        end else begin
          kind = CMD_NONE;
        end
      end
      MODE_CURSOR: kind = CMD_CURSOR;
      default:     kind = CMD_NONE;
    endcase
  end

  assign item_ready = !q_full;
  assign push       = item_valid && !q_full && (kind != CMD_NONE);

  assign cmd.kind = kind;
  assign cmd.code = item.char_code;
  assign cmd.fg   = item.fg_color;
  assign cmd.bg   = item.bg_color;
  assign cmd.fill = item.fill_background;
  assign cmd.row  = item.glyph_row;
  assign cmd.bits = item.glyph_bits;
  assign cmd.cx   = item.cursor_x;
  assign cmd.cy   = item.cursor_y;

endmodule

// ===== hw/rtl/tcgr_queue.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer command queue
// Short queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module tcgr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  tcgr_pkg::cmd_t push_cmd,
  input  logic           pop,
  output tcgr_pkg::cmd_t head,
  output logic           full,
  output logic           empty
);
  import tcgr_pkg::*;

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

`ifndef SYNTHESIS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("Queue popped while empty.");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("Queue pushed while full.");
`endif

endmodule

// ===== hw/rtl/tcgr_back.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer back end
// Runs the cursor sequencer, owns the font memory and drives the result
// register through a one-entry font read stage.
// ----------------------------------------------------------------------------
module tcgr_back #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  tcgr_pkg::cfg_t    cfg,
  input  logic              q_empty,
  input  tcgr_pkg::cmd_t    head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output tcgr_pkg::result_t result
);
  import tcgr_pkg::*;

  localparam int              FONT_DEPTH = GLYPH_COUNT * MAX_GLYPH_ROWS;
  localparam int              AW         = $clog2(FONT_DEPTH);
  localparam logic [AW-1:0]   ROWS_AW    = AW'(MAX_GLYPH_ROWS);
  localparam logic [5:0]      MAX_H      = 6'(MAX_GLYPH_ROWS);
  localparam logic [8:0]      CODE_LIMIT = 9'(GLYPH_COUNT);
  localparam logic [1:0]      TAB_LAST   = 2'(TAB_SPACES - 1);

  typedef struct packed {
    result_t item;
    logic    use_font;
  } stage_t;

  back_state_t   state;
  back_state_t   state_next;
  cmd_t          cmd;
  logic [15:0]   col;
  logic [15:0]   row;
  logic [15:0]   col_next;
  logic [15:0]   row_next;
  logic [15:0]   col_t;
  logic [15:0]   row_t;
  logic [4:0]    row_cnt;
  logic [1:0]    tab_cnt;
  logic [7:0]    font_mem [FONT_DEPTH];
  logic [7:0]    font_q;
  stage_t        s1;
  stage_t        issue_item;
  result_t       s1_out;
  logic          s1_valid;
  logic          s1_move;
  logic          s1_free;
  logic          issue;
  logic          rd_en;
  logic          wr_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [3:0]    eff_w;
  logic [4:0]    eff_h;
  logic [7:0]    mask;
  logic [7:0]    cur_code;
  logic          code_in_font;
  logic          x_over;
  logic          y_over;
  logic [15:0]   right_m_w;
  logic [15:0]   row_m_h;
  logic [15:0]   row_add_h;
  logic [15:0]   col_add_w;
  logic [15:0]   row_y_emit;
  logic [16:0]   nx;
  logic [16:0]   ny;
  logic          cur_ok;
  logic          last_row;

  assign eff_w = (cfg.glyph_width > 4'd8) ? 4'd8 : cfg.glyph_width;
  assign eff_h = ({1'b0, cfg.glyph_height} > MAX_H) ? MAX_H[4:0] : cfg.glyph_height;
  assign mask  = width_mask(eff_w);

  assign x_over     = ({1'b0, col} + 17'(eff_w)) > {1'b0, cfg.region_right};
  assign right_m_w  = sub0(cfg.region_right, 16'(eff_w));
  assign row_add_h  = sat16({1'b0, row} + 17'(eff_h));
  assign y_over     = ({1'b0, row} + 17'(eff_h)) > {1'b0, cfg.region_bottom};
  assign row_m_h    = sub0(row, 16'(eff_h));
  assign col_add_w  = sat16({1'b0, col} + 17'(eff_w));
  assign row_y_emit = sat16({1'b0, row} + 17'(row_cnt));

  assign nx     = {1'b0, cfg.region_left} + {1'b0, cmd.cx};
  assign ny     = {1'b0, cfg.region_top} + {1'b0, cmd.cy};
  assign cur_ok = (nx <= {1'b0, cfg.region_right}) && (ny <= {1'b0, cfg.region_bottom});

  assign cur_code     = (cmd.kind == CMD_TAB) ? CHAR_SPACE : cmd.code;
  assign code_in_font = ({1'b0, cur_code} < CODE_LIMIT);
  assign last_row     = (row_cnt == (eff_h - 5'd1));

  assign rd_addr = AW'(cur_code) * ROWS_AW + AW'(row_cnt);
  assign wr_addr = AW'(head.code) * ROWS_AW + AW'(head.row);

  assign s1_move = s1_valid && (!result_valid || result_ready);
  assign s1_free = !s1_valid || s1_move;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          case (head.kind)
            CMD_FONT:   state_next = ST_IDLE;
            CMD_CURSOR: state_next = ST_SETCUR;
            default:    state_next = ST_TRAP1_X;
          endcase
        end
      end
      ST_SETCUR: begin
        if (s1_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_TRAP1_X: state_next = ST_TRAP1_Y;
      ST_TRAP1_Y: state_next = ST_CTRL;
      ST_CTRL: begin
        case (cmd.kind)
          CMD_GLYPH, CMD_TAB: state_next = (eff_h == 5'd0) ? ST_ADV : ST_EMIT;
          default:            state_next = ST_TRAP2_X;
        endcase
      end
      ST_EMIT: begin
        if (s1_free && last_row) begin
          state_next = ST_ADV;
        end
      end
      ST_ADV: state_next = (cmd.kind == CMD_TAB) ? ST_TAB_X : ST_TRAP2_X;
      ST_TAB_X: state_next = ST_TAB_Y;
      ST_TAB_Y: begin
        if (tab_cnt == TAB_LAST) begin
          state_next = ST_TRAP2_X;
        end else begin
          state_next = (eff_h == 5'd0) ? ST_ADV : ST_EMIT;
        end
      end
      ST_TRAP2_X: state_next = ST_TRAP2_Y;
      ST_TRAP2_Y: state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    wr_en    = 1'b0;
    issue    = 1'b0;
    rd_en    = 1'b0;
    col_t    = col;
    row_t    = row;
    col_next = col;
    row_next = row;
    case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          pop   = 1'b1;
          wr_en = (head.kind == CMD_FONT);
        end
      end
      ST_SETCUR: begin
        issue = s1_free;
        if (s1_free && cur_ok) begin
          col_next = nx[15:0];
          row_next = ny[15:0];
        end
      end
      ST_TRAP1_X, ST_TAB_X, ST_TRAP2_X: begin
        if (x_over) begin
          if (cfg.wrap_enable) begin
            col_t    = cfg.region_left;
            row_next = row_add_h;
          end else begin
            col_t = right_m_w;
          end
        end
        col_next = (col_t < cfg.region_left) ? cfg.region_left : col_t;
      end
      ST_TRAP1_Y, ST_TAB_Y, ST_TRAP2_Y: begin
        if (y_over) begin
          if (cfg.wrap_enable) begin
            col_t = cfg.region_left;
            row_t = cfg.region_top;
          end else begin
            row_t = row_m_h;
          end
        end
        col_next = (col_t < cfg.region_left) ? cfg.region_left : col_t;
        row_next = (row_t < cfg.region_top) ? cfg.region_top : row_t;
      end
      ST_CTRL: begin
        if (cmd.kind == CMD_NEWLINE) begin
          row_next = row_add_h;
        end else if (cmd.kind == CMD_RETURN) begin
          col_next = cfg.region_left;
        end
      end
      ST_EMIT: begin
        issue = s1_free;
        rd_en = s1_free;
      end
      ST_ADV: col_next = col_add_w;
      default: ;
    endcase
  end

  always_comb begin
    issue_item = '0;
    if (state == ST_SETCUR) begin
      issue_item.item.status = !cur_ok;
      issue_item.item.last   = 1'b1;
    end else begin
      issue_item.item.row_x            = col;
      issue_item.item.row_y            = row_y_emit;
      issue_item.item.pixel_fg         = cmd.fg;
      issue_item.item.pixel_bg         = cmd.bg;
      issue_item.item.paint_background = cmd.fill;
      issue_item.item.last             = last_row &&
                                         ((cmd.kind == CMD_GLYPH) || (tab_cnt == TAB_LAST));
      issue_item.use_font              = code_in_font;
    end
  end

  always_comb begin
    s1_out          = s1.item;
    s1_out.row_bits = s1.use_font ? (font_q & mask) : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      col          <= '0;
      row          <= '0;
      row_cnt      <= '0;
      tab_cnt      <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      row   <= row_next;
      if ((state == ST_CTRL) || (state == ST_TAB_Y)) begin
        row_cnt <= '0;
      end else if ((state == ST_EMIT) && issue) begin
        row_cnt <= row_cnt + 5'd1;
      end
      if (state == ST_CTRL) begin
        tab_cnt <= '0;
      end else if (state == ST_TAB_Y) begin
        tab_cnt <= tab_cnt + 2'd1;
      end
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
    end
    if (issue) begin
      s1 <= issue_item;
    end
    if (s1_move) begin
      result <= s1_out;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      font_mem[wr_addr] <= head.bits;
    end
    if (rd_en) begin
      font_q <= font_mem[rd_addr];
    end
  end

`ifndef SYNTHESIS
  a_issue_fills: assert property (@(posedge clk) disable iff (rst) issue |=> s1_valid)
    else $error("Issued row did not reach the read stage.");
  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_move) |=> (s1_valid && $stable(s1)))
    else $error("Stalled read stage changed.");
  a_trap_bounds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TRAP1_Y) || (state == ST_TAB_Y) || (state == ST_TRAP2_Y)) |->
    ((col_next >= cfg.region_left) && (row_next >= cfg.region_top)))
    else $error("Cursor left the region after trapping.");
`endif

endmodule

// ===== hw/rtl/text_console_glyph_renderer_core.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer core
// Prints characters from a loaded bitmap font into a console region.
// ----------------------------------------------------------------------------
// Items enter on item_valid/item_ready and results leave on
// result_valid/result_ready; a transaction completes when both are high.
// Mode 0 prints a character, mode 1 loads one font row, mode 2 sets the cursor.
// A printed glyph yields one result per glyph row, at one row per cycle while
// results are not stalled, with last set on the character's final row; a tab
// yields four space glyphs. A printable character is popped, the cursor is
// trapped into the region in x and then in y, the character is dispatched, its
// rows are issued through the font memory read port, and the cursor advances
// and is trapped once more; a tab repeats rows, advance and trap per space.
// Newline and carriage return are trapped, applied and trapped again; a font
// load is written as it is popped and a set-cursor issues a status result.
// A two-entry command queue lets new items be accepted while rows drain.
// When the receiver stalls, the result register holds and the sequencer waits
// at the next row. Reset returns the cursor and registers to their defaults;
// font contents are undefined until loaded.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_core #(
  parameter int MAX_GLYPH_ROWS = 16,
  parameter int GLYPH_COUNT    = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  tcgr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output tcgr_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import tcgr_pkg::*;

  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_RIGHT  = 3'd2;
  localparam logic [2:0] REG_BOTTOM = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;
  localparam logic [2:0] REG_WRAP   = 3'd6;

  cfg_t cfg;
  logic cfg_write;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_left   <= 16'd0;
      cfg.region_top    <= 16'd0;
      cfg.region_right  <= 16'd640;
      cfg.region_bottom <= 16'd480;
      cfg.glyph_width   <= 4'd8;
      cfg.glyph_height  <= 5'd16;
      cfg.wrap_enable   <= 1'b1;
    end else if (cfg_write) begin
      case (paddr[4:2])
        REG_LEFT:   cfg.region_left   <= pwdata[15:0];
        REG_TOP:    cfg.region_top    <= pwdata[15:0];
        REG_RIGHT:  cfg.region_right  <= pwdata[15:0];
        REG_BOTTOM: cfg.region_bottom <= pwdata[15:0];
        REG_WIDTH:  cfg.glyph_width   <= pwdata[3:0];
        REG_HEIGHT: cfg.glyph_height  <= pwdata[4:0];
        REG_WRAP:   cfg.wrap_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_LEFT:   prdata = {16'd0, cfg.region_left};
      REG_TOP:    prdata = {16'd0, cfg.region_top};
      REG_RIGHT:  prdata = {16'd0, cfg.region_right};
      REG_BOTTOM: prdata = {16'd0, cfg.region_bottom};
      REG_WIDTH:  prdata = {28'd0, cfg.glyph_width};
      REG_HEIGHT: prdata = {27'd0, cfg.glyph_height};
      REG_WRAP:   prdata = {31'd0, cfg.wrap_enable};
      default:    prdata = 32'd0;
    endcase
  end

  tcgr_front #(
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) u_front (
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  tcgr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .full    (q_full),
    .empty   (q_empty)
  );

  tcgr_back #(
    .MAX_GLYPH_ROWS(MAX_GLYPH_ROWS),
    .GLYPH_COUNT   (GLYPH_COUNT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .q_empty     (q_empty),
    .head        (head),
    .pop         (pop),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule

// ===== bench/console_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Console renderer bench package
// Register addresses, the reset configuration and the effective glyph size
// rules that the stimulus and the checker both rely on.
// ----------------------------------------------------------------------------
package console_tb_pkg;
  import tcgr_pkg::*;

  typedef enum logic [4:0] {
    REG_REGION_LEFT   = 5'd0,
    REG_REGION_TOP    = 5'd4,
    REG_REGION_RIGHT  = 5'd8,
    REG_REGION_BOTTOM = 5'd12,
    REG_GLYPH_WIDTH   = 5'd16,
    REG_GLYPH_HEIGHT  = 5'd20,
    REG_WRAP_ENABLE   = 5'd24
  } reg_addr_t;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         FONT_ROWS   = 16;
  localparam int         FONT_COLS   = 8;

  localparam cfg_t RESET_CFG = '{
    region_left:   16'd0,
    region_top:    16'd0,
    region_right:  16'd640,
    region_bottom: 16'd480,
    glyph_width:   4'd8,
    glyph_height:  5'd16,
    wrap_enable:   1'b1
  };

  // Oversized glyph dimensions are limited to what the font store holds.
  function automatic logic [15:0] rows_drawn(input cfg_t c);
    return (c.glyph_height > FONT_ROWS) ? 16'(FONT_ROWS) : 16'(c.glyph_height);
  endfunction

  function automatic logic [15:0] cols_drawn(input cfg_t c);
    return (c.glyph_width > FONT_COLS) ? 16'(FONT_COLS) : 16'(c.glyph_width);
  endfunction

endpackage

// ===== bench/glyph_row_checker.sv =====
// ----------------------------------------------------------------------------
// Glyph row checker
// Watches the item, result and register ports of the console renderer,
// predicts every glyph row and cursor status, and compares each result
// transaction with the oldest prediction.
// ----------------------------------------------------------------------------
module glyph_row_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  tcgr_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  tcgr_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                outstanding,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcgr_pkg::*;
  import console_tb_pkg::*;

  cfg_t        regs;
  logic [15:0] pen_x;
  logic [15:0] pen_y;
  logic [7:0]  font_rows [0:4095];
  result_t     expected_rows [$];
  int          mismatches = 0;

  assign fail_count = mismatches;

  function automatic logic [15:0] add_sat(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  function automatic logic [15:0] sub_floor(input logic [15:0] a, input logic [15:0] b);
    return (a >= b) ? a - b : 16'd0;
  endfunction

  task automatic confine_pen();
    logic [15:0] w;
    logic [15:0] h;
    w = cols_drawn(regs);
    h = rows_drawn(regs);
    if ({1'b0, pen_x} + {1'b0, w} > {1'b0, regs.region_right}) begin
      if (regs.wrap_enable) begin
        pen_x = regs.region_left;
        pen_y = add_sat(pen_y, h);
      end else begin
        pen_x = sub_floor(regs.region_right, w);
      end
    end
    if ({1'b0, pen_y} + {1'b0, h} > {1'b0, regs.region_bottom}) begin
      if (regs.wrap_enable) begin
        pen_x = regs.region_left;
        pen_y = regs.region_top;
      end else begin
        pen_y = sub_floor(pen_y, h);
      end
    end
    if (pen_x < regs.region_left) pen_x = regs.region_left;
    if (pen_y < regs.region_top) pen_y = regs.region_top;
  endtask

  task automatic draw_glyph(input logic [7:0] code, input item_t it);
    result_t     r;
    logic [15:0] h;
    logic [15:0] w;
    logic [7:0]  mask;
    h = rows_drawn(regs);
    w = cols_drawn(regs);
    mask = 8'hFF << (16'd8 - w);
    for (int i = 0; i < h; i++) begin
      r = '0;
      r.row_x = pen_x;
      r.row_y = add_sat(pen_y, 16'(i));
      r.row_bits = font_rows[{code, 4'(i)}] & mask;
      r.pixel_fg = it.fg_color;
      r.pixel_bg = it.bg_color;
      r.paint_background = it.fill_background;
      expected_rows.push_back(r);
    end
    pen_x = add_sat(pen_x, w);
  endtask

  task automatic render_item(input item_t it);
    result_t     r;
    int          queued;
    logic [16:0] want_x;
    logic [16:0] want_y;
    logic        in_region;
    queued = expected_rows.size();
    case (it.mode)
      MODE_CHAR: begin
        confine_pen();
        if (it.char_code == CHAR_NEWLINE) begin
          pen_y = add_sat(pen_y, rows_drawn(regs));
        end else if (it.char_code == CHAR_RETURN) begin
          pen_x = regs.region_left;
        end else if (it.char_code == CHAR_TAB) begin
          repeat (TAB_SPACES) begin
            draw_glyph(CHAR_SPACE, it);
            confine_pen();
          end
        end else begin
          draw_glyph(it.char_code, it);
        end
        confine_pen();
        if (expected_rows.size() > queued) begin
          r = expected_rows.pop_back();
          r.last = 1'b1;
          expected_rows.push_back(r);
        end
      end
      MODE_FONT: begin
        font_rows[{it.char_code, it.glyph_row}] = it.glyph_bits;
      end
      MODE_CURSOR: begin
        want_x = {1'b0, regs.region_left} + {1'b0, it.cursor_x};
        want_y = {1'b0, regs.region_top} + {1'b0, it.cursor_y};
        in_region = (want_x <= {1'b0, regs.region_right}) &&
                    (want_y <= {1'b0, regs.region_bottom});
        if (in_region) begin
          pen_x = want_x[15:0];
          pen_y = want_y[15:0];
        end
        r = '0;
        r.status = !in_region;
        r.last = 1'b1;
        expected_rows.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s expected %0h actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      regs = RESET_CFG;
      pen_x = 16'd0;
      pen_y = 16'd0;
      expected_rows.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (expected_rows.size() == 0) begin
          $error("result transaction with nothing expected: row_x %0h row_y %0h",
                 result.row_x, result.row_y);
          mismatches++;
        end else begin
          want = expected_rows.pop_front();
          check_field("row_x", want.row_x, result.row_x);
          check_field("row_y", want.row_y, result.row_y);
          check_field("row_bits", want.row_bits, result.row_bits);
          check_field("pixel_fg", want.pixel_fg, result.pixel_fg);
          check_field("pixel_bg", want.pixel_bg, result.pixel_bg);
          check_field("paint_background", want.paint_background,
                      result.paint_background);
          check_field("status", want.status, result.status);
          check_field("last", want.last, result.last);
        end
      end
      if (item_valid && item_ready) render_item(item);
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          REG_REGION_LEFT:   regs.region_left = pwdata[15:0];
          REG_REGION_TOP:    regs.region_top = pwdata[15:0];
          REG_REGION_RIGHT:  regs.region_right = pwdata[15:0];
          REG_REGION_BOTTOM: regs.region_bottom = pwdata[15:0];
          REG_GLYPH_WIDTH:   regs.glyph_width = pwdata[3:0];
          REG_GLYPH_HEIGHT:  regs.glyph_height = pwdata[4:0];
          REG_WRAP_ENABLE:   regs.wrap_enable = pwdata[0];
          default: begin
          end
        endcase
      end
    end
    outstanding <= expected_rows.size();
  end

endmodule

// ===== bench/tb_text_console_glyph_renderer_core.sv =====
// ----------------------------------------------------------------------------
// Text console glyph renderer testbench
// Loads font rows, prints characters and control codes, and moves the cursor
// under a series of region and glyph settings, with random gaps on the item
// side and random stalls on the result side in all but the last phase. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_text_console_glyph_renderer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tcgr_pkg::*;
  import console_tb_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 11;
  localparam int PHASES      = 7;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          outstanding;
  int          fail_count;

  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_results = 1'b0;
  cfg_t        console;
  bit          font_written [0:255][0:15];
  logic [7:0]  glyph_pool [$];

  always #4 clk = ~clk;

  text_console_glyph_renderer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  glyph_row_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .outstanding  (outstanding),
    .fail_count   (fail_count)
  );

  function automatic item_t random_item();
    item_t it;
    it.mode = MODE_CHAR;
    it.char_code = 8'($urandom);
    it.fg_color = $urandom;
    it.bg_color = $urandom;
    it.fill_background = 1'($urandom);
    it.glyph_row = 4'($urandom);
    it.glyph_bits = 8'($urandom);
    it.cursor_x = 16'($urandom);
    it.cursor_y = 16'($urandom);
    return it;
  endfunction

  function automatic item_t char_item(input logic [7:0] code);
    item_t it;
    it = random_item();
    it.char_code = code;
    return it;
  endfunction

  function automatic item_t cursor_item(input logic [15:0] x, input logic [15:0] y);
    item_t it;
    it = random_item();
    it.mode = MODE_CURSOR;
    it.cursor_x = x;
    it.cursor_y = y;
    return it;
  endfunction

  function automatic item_t font_item(input logic [7:0] code, input logic [3:0] row,
                                      input logic [7:0] bits);
    item_t it;
    it = random_item();
    it.mode = MODE_FONT;
    it.char_code = code;
    it.glyph_row = row;
    it.glyph_bits = bits;
    return it;
  endfunction

  task automatic push_item(input item_t it);
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    if (it.mode == MODE_FONT) font_written[it.char_code][it.glyph_row] = 1'b1;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Every row that the current glyph height reads must be loaded first.
  task automatic ensure_glyph(input logic [7:0] code);
    for (int r = 0; r < rows_drawn(console); r++) begin
      if (!font_written[code][r]) push_item(font_item(code, 4'(r), 8'($urandom)));
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic apb_write(input reg_addr_t addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic write_config(input cfg_t c);
    apb_write(REG_REGION_LEFT, 32'(c.region_left));
    apb_write(REG_REGION_TOP, 32'(c.region_top));
    apb_write(REG_REGION_RIGHT, 32'(c.region_right));
    apb_write(REG_REGION_BOTTOM, 32'(c.region_bottom));
    apb_write(REG_GLYPH_WIDTH, 32'(c.glyph_width));
    apb_write(REG_GLYPH_HEIGHT, 32'(c.glyph_height));
    apb_write(REG_WRAP_ENABLE, 32'(c.wrap_enable));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    console = c;
  endtask

  task automatic random_step();
    item_t      it;
    int         pick;
    int         span_x;
    int         span_y;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    span_x = int'(console.region_right) - int'(console.region_left);
    span_y = int'(console.region_bottom) - int'(console.region_top);
    if (pick < 10) begin
      it = cursor_item(16'($urandom), 16'($urandom));
      if (span_x >= 0 && span_y >= 0 && $urandom_range(0, 1) == 1) begin
        it.cursor_x = 16'($urandom_range(0, span_x));
        it.cursor_y = 16'($urandom_range(0, span_y));
      end
      push_item(it);
    end else if (pick < 16) begin
      push_item(font_item(8'($urandom), 4'($urandom), 8'($urandom)));
    end else if (pick < 20) begin
      it = random_item();
      it.mode = MODE_UNUSED;
      push_item(it);
    end else if (pick < 28) begin
      push_item(char_item(CHAR_NEWLINE));
    end else if (pick < 33) begin
      push_item(char_item(CHAR_RETURN));
    end else if (pick < 38) begin
      ensure_glyph(CHAR_SPACE);
      push_item(char_item(CHAR_TAB));
    end else begin
      if ($urandom_range(0, 15) == 0) begin
        code = 8'($urandom);
        glyph_pool.push_back(code);
      end else begin
        code = glyph_pool[$urandom_range(0, glyph_pool.size() - 1)];
      end
      ensure_glyph(code);
      push_item(char_item(code));
    end
  endtask

  initial begin : result_sink
    result_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_results) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_ready <= 1'b1;
        hold_results = 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        result_ready <= 1'b1;
      end else begin
        result_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    item_t it;
    cfg_t  plan [PHASES];
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    console = RESET_CFG;
    glyph_pool = '{CHAR_SPACE, 8'h00, 8'hFF};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The reset region accepts its own corner as a cursor position.
    push_item(cursor_item(16'd640, 16'd480));
    push_item(char_item(CHAR_NEWLINE));
    settle();

    write_config('{16'd0, 16'd0, 16'd640, 16'd480, 4'd8, 5'd3, 1'b1});
    push_item(font_item(8'hFF, 4'd0, 8'hFF));
    push_item(font_item(8'hFF, 4'd1, 8'h00));
    push_item(font_item(8'hFF, 4'd2, 8'h81));
    ensure_glyph(8'h00);
    ensure_glyph(CHAR_SPACE);
    it = char_item(8'h00);
    it.fg_color = 32'h0;
    it.bg_color = 32'h0;
    it.fill_background = 1'b0;
    push_item(it);
    it = char_item(8'hFF);
    it.fg_color = 32'hFFFF_FFFF;
    it.bg_color = 32'hFFFF_FFFF;
    it.fill_background = 1'b1;
    push_item(it);
    push_item(char_item(CHAR_TAB));
    push_item(char_item(CHAR_RETURN));
    push_item(char_item(CHAR_NEWLINE));
    push_item(cursor_item(16'd0, 16'd0));
    push_item(cursor_item(16'd640, 16'd480));
    push_item(char_item(8'hFF));
    push_item(cursor_item(16'd641, 16'd0));
    push_item(cursor_item(16'hFFFF, 16'hFFFF));
    it = random_item();
    it.mode = MODE_UNUSED;
    push_item(it);

    plan[0] = '{16'd0, 16'd0, 16'd640, 16'd480, 4'd8, 5'd16, 1'b1};
    plan[1] = '{16'd100, 16'd50, 16'd180, 16'd120, 4'd15, 5'd31, 1'b0};
    plan[2] = '{16'd65500, 16'd65480, 16'hFFFF, 16'hFFFF, 4'd5, 5'd7, 1'b1};
    plan[3] = '{16'd0, 16'd0, 16'd20, 16'd20, 4'd0, 5'd0, 1'b1};
    plan[4] = '{16'd300, 16'd200, 16'd100, 16'd50, 4'd3, 5'd4, 1'b0};
    plan[5] = '{16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 4'd1, 5'd1, 1'b1};
    plan[6].region_left = 16'($urandom_range(0, 1000));
    plan[6].region_top = 16'($urandom_range(0, 1000));
    plan[6].region_right = plan[6].region_left + 16'($urandom_range(8, 400));
    plan[6].region_bottom = plan[6].region_top + 16'($urandom_range(16, 300));
    plan[6].glyph_width = 4'($urandom_range(1, 8));
    plan[6].glyph_height = 5'($urandom_range(1, 16));
    plan[6].wrap_enable = 1'($urandom);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_config(plan[p]);
      if (p == PHASES - 1) begin
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      if (p == 0) hold_results = 1'b1;
      repeat (PHASE_ITEMS) random_step();
    end
    settle();

    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
